// ----- hdl/rfd_pkg.sv -----
// Shared types, character codes and sizing for the RESP2 response frame detector.
// No dependencies; used by resp_response_frame_detector and rfd_checker.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int MAX_DEPTH    = 16;
  localparam int NUMBER_CHARS = 31;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W   = $clog2(NUMBER_CHARS + 1);
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 31;

  localparam logic [LEN_W-1:0] LEN_LIMIT = {LEN_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_SAT   = VAL_W'(1) << LEN_W;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LINE,
    PH_NUMBER,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE      = 2'd0,
    ST_DONE      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEC_WS     = 2'd0,
    SEC_SIGN   = 2'd1,
    SEC_DIGITS = 2'd2
  } section_e;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             negative;
    logic [CNT_W-1:0] count;
    section_e         section;
    logic             bad;
  } number_t;

  // One character of a length line. Value saturates just above 2^31-1.
  function automatic number_t number_char(number_t s, logic [7:0] c);
    number_t            r;
    logic               digit;
    logic               space;
    logic [VAL_W+3:0]   prod;
    r     = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    prod  = '0;
    if (s.count >= CNT_W'(NUMBER_CHARS)) begin
      r.bad = 1'b1;
    end else begin
      r.count = s.count + CNT_W'(1);
    end
    if ((s.section == SEC_WS) && space) begin
      r.section = SEC_WS;
    end else if ((s.section == SEC_WS) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
      r.negative = (c == CH_MINUS);
      r.section  = SEC_SIGN;
    end else if (!digit) begin
      r.bad = 1'b1;
    end else begin
      r.section = SEC_DIGITS;
      prod = ({4'b0000, s.value} << 3) + ({4'b0000, s.value} << 1)
           + (VAL_W + 4)'(4'(c - CH_ZERO));
      r.value = (prod > (VAL_W + 4)'(VAL_SAT)) ? VAL_SAT : prod[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/resp_response_frame_detector.sv -----
// RESP2 response frame detector, top level: parser state, count stack, output skid.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel: one response byte per request (data_byte_i) with restart_i;
//   restart_i drops any partial frame or sticky result and makes this byte the
//   first of a new frame. Accepted when in_valid_i and in_ready_o are high.
//   Result channel: one result per request, in order: status_o (0 need more,
//   1 complete, 2 malformed) and frame_length_o (byte count when complete,
//   else zero). Taken when out_valid_o and out_ready_i are high.
// Result path and throughput
//   The result of a byte is registered in the result register, or in the skid entry.
//   One byte per cycle is sustained while in_ready_o is high; all parsing of a
//   byte, including the unwinding of nested arrays, is one pass of logic between
//   the parser state and the result register. Array completion searches the count
//   stack in parallel for the deepest level that still has more than one element due.
// Stall
//   A two-entry output (result register plus skid) keeps accepting while one
//   result waits; in_ready_o drops only when both entries hold results.
// Reset
//   rst_ni clears the parser to expect a type byte and empties the output.
//   The count stack has no reset: levels are only read after being pushed.
// Once complete or malformed, further bytes repeat that result until restart.

module resp_response_frame_detector (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [rfd_pkg::LEN_W-1:0] frame_length_o
);

  localparam int MaxDepth = rfd_pkg::MAX_DEPTH;
  localparam int DepthW   = rfd_pkg::DEPTH_W;
  localparam int IdxW     = rfd_pkg::IDX_W;
  localparam int LenW     = rfd_pkg::LEN_W;
  localparam int ValW     = rfd_pkg::VAL_W;

  // parser state
  rfd_pkg::phase_e    phase_q, phase_d;
  rfd_pkg::number_t   num_q, num_d;
  logic               line_kind_q, line_kind_d;   // 0 bulk length, 1 array count
  logic               prev_cr_q, prev_cr_d;
  logic [LenW-1:0]    bulk_q, bulk_d;
  logic [DepthW-1:0]  level_q, level_d;
  logic [LenW-1:0]    seen_q, seen_d;

  // count stack, with a flag per level for "exactly one element left"
  logic [LenW-1:0]    counts_q [MaxDepth];
  logic [MaxDepth-1:0] one_q;

  // state seen by the current byte (restart applied)
  rfd_pkg::phase_e    phase_c;
  rfd_pkg::number_t   num_c;
  rfd_pkg::number_t   num_cr;
  logic               line_kind_c;
  logic               prev_cr_c;
  logic [DepthW-1:0]  level_c;
  logic [LenW-1:0]    seen_c;

  // element completion
  logic               ec_found;
  logic [IdxW-1:0]    ec_idx;
  logic [LenW-1:0]    ec_cnt;
  logic               ec_go;
  logic               dec_en;
  logic               push_en;
  logic               neg;

  // result
  logic [1:0]         res_status;
  logic [LenW-1:0]    res_len;

  // output register and skid
  logic               out_valid_q, skid_valid_q;
  logic [1:0]         out_status_q, skid_status_q;
  logic [LenW-1:0]    out_len_q, skid_len_q;
  logic               in_fire, out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    phase_c     = restart_i ? rfd_pkg::PH_TYPE : phase_q;
    num_c       = restart_i ? '0 : num_q;
    line_kind_c = restart_i ? 1'b0 : line_kind_q;
    prev_cr_c   = restart_i ? 1'b0 : prev_cr_q;
    level_c     = restart_i ? '0 : level_q;
    seen_c      = restart_i ? '0 : seen_q;
  end

  // deepest pending level that does not close on this element
  always_comb begin
    ec_found = 1'b0;
    ec_idx   = '0;
    for (int i = 0; i < MaxDepth; i++) begin
      if ((DepthW'(i) < level_c) && !one_q[i]) begin
        ec_found = 1'b1;
        ec_idx   = IdxW'(i);
      end
    end
    ec_cnt = counts_q[ec_idx];
  end

  always_comb begin
    phase_d     = phase_c;
    num_d       = num_c;
    line_kind_d = line_kind_c;
    prev_cr_d   = prev_cr_c;
    bulk_d      = bulk_q;
    level_d     = level_c;
    seen_d      = seen_c;
    ec_go       = 1'b0;
    push_en     = 1'b0;
    dec_en      = 1'b0;
    neg         = num_c.negative && (num_c.value != '0);
    num_cr      = prev_cr_c ? rfd_pkg::number_char(num_c, rfd_pkg::CH_CR) : num_c;

    if ((phase_c != rfd_pkg::PH_DONE) && (phase_c != rfd_pkg::PH_ERROR)) begin
      if (seen_c >= rfd_pkg::LEN_LIMIT) begin
        phase_d = rfd_pkg::PH_ERROR;
      end else begin
        seen_d = seen_c + LenW'(1);
        unique case (phase_c)
          rfd_pkg::PH_TYPE: begin
            if ((data_byte_i == rfd_pkg::CH_PLUS) || (data_byte_i == rfd_pkg::CH_MINUS) ||
                (data_byte_i == rfd_pkg::CH_COLON)) begin
              prev_cr_d = 1'b0;
              phase_d   = rfd_pkg::PH_LINE;
            end else if ((data_byte_i == rfd_pkg::CH_DOLLAR) ||
                         (data_byte_i == rfd_pkg::CH_STAR)) begin
              line_kind_d = (data_byte_i == rfd_pkg::CH_STAR);
              num_d       = '0;
              prev_cr_d   = 1'b0;
              phase_d     = rfd_pkg::PH_NUMBER;
            end else begin
              phase_d = rfd_pkg::PH_ERROR;
            end
          end
          rfd_pkg::PH_LINE: begin
            if (prev_cr_c && (data_byte_i == rfd_pkg::CH_LF)) begin
              ec_go = 1'b1;
            end else begin
              prev_cr_d = (data_byte_i == rfd_pkg::CH_CR);
            end
          end
          rfd_pkg::PH_NUMBER: begin
            if (prev_cr_c && (data_byte_i == rfd_pkg::CH_LF)) begin
              // judge the line
              if ((num_c.count == '0) || num_c.bad ||
                  (num_c.section != rfd_pkg::SEC_DIGITS)) begin
                phase_d = rfd_pkg::PH_ERROR;
              end else if (!neg && num_c.value[ValW-1]) begin
                phase_d = rfd_pkg::PH_ERROR;
              end else if (!line_kind_c) begin
                if (neg) begin
                  ec_go = 1'b1;
                end else begin
                  bulk_d    = num_c.value[LenW-1:0];
                  prev_cr_d = 1'b0;
                  phase_d   = (num_c.value == '0) ? rfd_pkg::PH_TRAIL1 : rfd_pkg::PH_DATA;
                end
              end else if (neg || (num_c.value == '0)) begin
                ec_go = 1'b1;
              end else if (level_c >= DepthW'(MaxDepth)) begin
                phase_d = rfd_pkg::PH_ERROR;
              end else begin
                push_en = 1'b1;
                level_d = level_c + DepthW'(1);
                phase_d = rfd_pkg::PH_TYPE;
              end
            end else if (data_byte_i == rfd_pkg::CH_CR) begin
              // a pending CR not followed by LF counts as a line character
              num_d     = num_cr;
              prev_cr_d = 1'b1;
            end else begin
              num_d     = rfd_pkg::number_char(num_cr, data_byte_i);
              prev_cr_d = 1'b0;
            end
          end
          rfd_pkg::PH_DATA: begin
            bulk_d = bulk_q - LenW'(1);
            if (bulk_d == '0) begin
              phase_d = rfd_pkg::PH_TRAIL1;
            end
          end
          rfd_pkg::PH_TRAIL1: begin
            prev_cr_d = (data_byte_i == rfd_pkg::CH_CR);
            phase_d   = rfd_pkg::PH_TRAIL2;
          end
          default: begin
            if (prev_cr_c && (data_byte_i == rfd_pkg::CH_LF)) begin
              ec_go = 1'b1;
            end else begin
              phase_d = rfd_pkg::PH_ERROR;
            end
          end
        endcase

        if (ec_go) begin
          if (ec_found) begin
            dec_en  = 1'b1;
            level_d = DepthW'(ec_idx) + DepthW'(1);
            phase_d = rfd_pkg::PH_TYPE;
          end else begin
            level_d = '0;
            phase_d = rfd_pkg::PH_DONE;
          end
        end
      end
    end

    if (phase_d == rfd_pkg::PH_DONE) begin
      res_status = rfd_pkg::ST_DONE;
      res_len    = seen_d;
    end else if (phase_d == rfd_pkg::PH_ERROR) begin
      res_status = rfd_pkg::ST_MALFORMED;
      res_len    = '0;
    end else begin
      res_status = rfd_pkg::ST_MORE;
      res_len    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rfd_pkg::PH_TYPE;
      num_q       <= '0;
      line_kind_q <= 1'b0;
      prev_cr_q   <= 1'b0;
      bulk_q      <= '0;
      level_q     <= '0;
      seen_q      <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      num_q       <= num_d;
      line_kind_q <= line_kind_d;
      prev_cr_q   <= prev_cr_d;
      bulk_q      <= bulk_d;
      level_q     <= level_d;
      seen_q      <= seen_d;
    end
  end

  // stack writes: decrement the surviving level, or push a new count
  always_ff @(posedge clk_i) begin
    if (in_fire && dec_en) begin
      counts_q[ec_idx] <= ec_cnt - LenW'(1);
      one_q[ec_idx]    <= (ec_cnt == LenW'(2));
    end else if (in_fire && push_en) begin
      counts_q[level_c[IdxW-1:0]] <= num_c.value[LenW-1:0];
      one_q[level_c[IdxW-1:0]]    <= (num_c.value == ValW'(1));
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_status_q <= skid_status_q;
        out_len_q    <= skid_len_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_status_q <= res_status;
        out_len_q    <= res_len;
      end else begin
        skid_status_q <= res_status;
        skid_len_q    <= res_len;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_length_o = out_len_q;

endmodule

// ----- hdl/rfd_checker.sv -----
// Port-level checks for the RESP2 response frame detector, bound to the top level.
// Depends on rfd_pkg and resp_response_frame_detector.
`timescale 1ns / 1ps

module rfd_port_checks (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [1:0]                status_o,
  input logic [rfd_pkg::LEN_W-1:0] frame_length_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(frame_length_o))
    else $error("stalled result changed");

  // back-pressure only when a result is waiting
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request refused with no result waiting");

  // length only on completion, and a complete frame has at least type, CR, LF
  a_len_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rfd_pkg::ST_DONE) |-> (frame_length_o == '0))
    else $error("length reported without completion");

  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rfd_pkg::ST_DONE) |-> (frame_length_o >= 3))
    else $error("completed frame too short");

endmodule

bind resp_response_frame_detector rfd_port_checks u_rfd_checker (.*);

// ----- test/rfd_checker.sv -----
// Checker for the RESP2 response frame detector: keeps its own model of the parser,
// predicts one result per accepted request and compares it with the result channel.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      restart_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [1:0]                status_i,
  input  logic [rfd_pkg::LEN_W-1:0] frame_length_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        complete_count_o,
  output int                        malformed_count_o
);

  import rfd_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] length;
  } frame_result_t;

  // Parser state as seen from the protocol
  phase_e      ph;
  logic        count_line;      // 0 bulk length line, 1 array count line
  logic [31:0] num_val;
  logic        num_neg;
  int          num_chars;
  section_e    num_sec;
  logic        num_bad;
  logic        prev_cr;
  logic [31:0] bulk_left;
  logic [31:0] count_stack [MAX_DEPTH];
  int          depth;
  logic [31:0] frame_bytes;

  frame_result_t result_q [$];
  frame_result_t head_exp;
  status_e       st_new;
  logic [LEN_W-1:0] len_new;
  int            result_index;

  function automatic void clear_parser();
    ph          = PH_TYPE;
    count_line  = 1'b0;
    num_val     = '0;
    num_neg     = 1'b0;
    num_chars   = 0;
    num_sec     = SEC_WS;
    num_bad     = 1'b0;
    prev_cr     = 1'b0;
    bulk_left   = '0;
    depth       = 0;
    frame_bytes = '0;
  endfunction

  function automatic void open_number(logic is_count);
    count_line = is_count;
    num_val    = '0;
    num_neg    = 1'b0;
    num_chars  = 0;
    num_sec    = SEC_WS;
    num_bad    = 1'b0;
    prev_cr    = 1'b0;
    ph         = PH_NUMBER;
  endfunction

  // One element finished: unwind every array level whose last element it was.
  function automatic void close_element();
    while (depth > 0) begin
      count_stack[depth-1] = count_stack[depth-1] - 32'd1;
      if (count_stack[depth-1] != 32'd0) begin
        ph = PH_TYPE;
        return;
      end
      depth = depth - 1;
    end
    ph = PH_DONE;
  endfunction

  function automatic void number_text(logic [7:0] c);
    logic            is_digit;
    longint unsigned acc;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (num_chars >= NUMBER_CHARS) num_bad = 1'b1;
    else num_chars = num_chars + 1;
    if (num_sec == SEC_WS) begin
      if ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR))) return;
      if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        num_neg = (c == CH_MINUS);
        num_sec = SEC_SIGN;
        return;
      end
    end
    if (!is_digit) begin
      num_bad = 1'b1;
      return;
    end
    num_sec = SEC_DIGITS;
    acc = longint'(num_val) * 10 + longint'(c - CH_ZERO);
    if (acc > 64'h8000_0000) num_val = 32'h8000_0000;
    else num_val = acc[31:0];
  endfunction

  // Length or count line closed by CR LF
  function automatic void judge_number();
    logic neg;
    if ((num_chars == 0) || num_bad || (num_sec != SEC_DIGITS)) begin
      ph = PH_ERROR;
      return;
    end
    neg = num_neg && (num_val != 32'd0);
    if (!neg && (num_val > 32'h7FFF_FFFF)) begin
      ph = PH_ERROR;
      return;
    end
    if (!count_line) begin
      if (neg) begin
        close_element();
        return;
      end
      bulk_left = num_val;
      prev_cr   = 1'b0;
      if (num_val == 32'd0) ph = PH_TRAIL1;
      else ph = PH_DATA;
      return;
    end
    if (neg || (num_val == 32'd0)) begin
      close_element();
      return;
    end
    if (depth >= MAX_DEPTH) begin
      ph = PH_ERROR;
      return;
    end
    count_stack[depth] = num_val;
    depth = depth + 1;
    ph = PH_TYPE;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic rs,
                            output status_e st, output logic [LEN_W-1:0] len);
    if (rs) clear_parser();
    if ((ph != PH_DONE) && (ph != PH_ERROR)) begin
      if (frame_bytes >= 32'h7FFF_FFFF) begin
        ph = PH_ERROR;
      end else begin
        frame_bytes = frame_bytes + 32'd1;
        case (ph)
          PH_TYPE: begin
            if ((b == CH_PLUS) || (b == CH_MINUS) || (b == CH_COLON)) begin
              prev_cr = 1'b0;
              ph = PH_LINE;
            end else if (b == CH_DOLLAR) begin
              open_number(1'b0);
            end else if (b == CH_STAR) begin
              open_number(1'b1);
            end else begin
              ph = PH_ERROR;
            end
          end
          PH_LINE: begin
            if (prev_cr && (b == CH_LF)) close_element();
            else prev_cr = (b == CH_CR);
          end
          PH_NUMBER: begin
            if (prev_cr && (b == CH_LF)) begin
              judge_number();
            end else begin
              // a CR not followed by LF counts as line content
              if (prev_cr) number_text(CH_CR);
              if (b == CH_CR) begin
                prev_cr = 1'b1;
              end else begin
                prev_cr = 1'b0;
                number_text(b);
              end
            end
          end
          PH_DATA: begin
            bulk_left = bulk_left - 32'd1;
            if (bulk_left == 32'd0) ph = PH_TRAIL1;
          end
          PH_TRAIL1: begin
            prev_cr = (b == CH_CR);
            ph = PH_TRAIL2;
          end
          default: begin
            if (prev_cr && (b == CH_LF)) close_element();
            else ph = PH_ERROR;
          end
        endcase
      end
    end
    if (ph == PH_DONE) begin
      st  = ST_DONE;
      len = frame_bytes[LEN_W-1:0];
    end else if (ph == PH_ERROR) begin
      st  = ST_MALFORMED;
      len = '0;
    end else begin
      st  = ST_MORE;
      len = '0;
    end
  endtask

  function automatic void count_failure();
    fail_count_o = fail_count_o + 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      result_q.delete();
      pending_o         = 0;
      fail_count_o      = 0;
      complete_count_o  = 0;
      malformed_count_o = 0;
      result_index      = 0;
    end else begin
      // results first: a result taken now belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (status_i == ST_DONE) complete_count_o = complete_count_o + 1;
        if (status_i == ST_MALFORMED) malformed_count_o = malformed_count_o + 1;
        if (result_q.size() == 0) begin
          count_failure();
          if (fail_count_o <= 10)
            $display("[%0t] result %0d with no request pending: status %0d length %0d",
                     $realtime, result_index, status_i, frame_length_i);
        end else begin
          head_exp = result_q.pop_front();
          if ((status_i != head_exp.status) || (frame_length_i != head_exp.length)) begin
            count_failure();
            if (fail_count_o <= 10)
              $display("[%0t] result %0d mismatch: expected status %0d length %0d, got %0d %0d",
                       $realtime, result_index, head_exp.status, head_exp.length,
                       status_i, frame_length_i);
          end
        end
        result_index = result_index + 1;
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(data_byte_i, restart_i, st_new, len_new);
        result_q.push_back('{status: st_new, length: len_new});
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ----- test/tb_resp_response_frame_detector.sv -----
// Testbench top for resp_response_frame_detector: builds RESP2 byte streams, drives
// the request channel in bursts, stalls the result channel, gives the verdict.
// Depends on rfd_pkg, rfd_checker and the block itself.
`timescale 1ns / 1ps

module tb_resp_response_frame_detector;

  import rfd_pkg::*;

  localparam int          TARGET_REQS = 1400;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int          HOLD_AFTER  = 400;   // requests accepted before it starts
  localparam logic [7:0]  CH_VT       = 8'd11;
  localparam logic [7:0]  CH_FF       = 8'd12;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i = 8'h00;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [LEN_W-1:0]     frame_length_o;

  int fail_count;
  int pending;
  int complete_count;
  int malformed_count;

  // request stream: {restart, byte}; frame_q is the frame under construction
  logic [8:0] byte_q  [$];
  logic [7:0] frame_q [$];
  int         req_count   = 0;
  int         frame_count = 0;
  int         cycle_count = 0;
  logic       hold_taken  = 1'b0;

  always #6 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  resp_response_frame_detector u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_length_o (frame_length_o)
  );

  rfd_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .restart_i         (restart_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .frame_length_i    (frame_length_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .complete_count_o  (complete_count),
    .malformed_count_o (malformed_count)
  );

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------

  function automatic void put(logic [7:0] c);
    frame_q.push_back(c);
  endfunction

  function automatic void put_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_crlf();
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic logic last_is_cr();
    return (frame_q.size() > 0) && (frame_q[$] == CH_CR);
  endfunction

  // Any byte, except an LF straight after a CR, which would close the line early
  function automatic void put_text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c == CH_LF) && last_is_cr()) c = CH_SPACE;
    put(c);
  endfunction

  // Leading whitespace of a length line; a lone CR is whitespace too
  function automatic void put_ws();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = CH_LF;
      3:       c = CH_VT;
      4:       c = CH_FF;
      default: c = CH_CR;
    endcase
    if ((c == CH_LF) && last_is_cr()) c = CH_SPACE;
    put(c);
  endfunction

  // Text of a length/count line (without CR LF). usable means the parser will
  // go on with value val: -1 for nil/empty, else a small element count or size.
  function automatic void put_number(input logic is_count, output int val,
                                     output logic usable);
    int   n;
    int   s;
    logic neg;
    usable = 1'b0;
    val    = 0;
    if ($urandom_range(0, 99) < 78) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put_ws();
      n   = is_count ? $urandom_range(0, 3) : $urandom_range(0, 12);
      neg = 1'b0;
      s   = $urandom_range(0, 9);
      if (s == 0) begin
        put(CH_MINUS);
        neg = 1'b1;
      end else if (s == 1) begin
        put(CH_PLUS);
      end
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) put(CH_ZERO);
      put_str($sformatf("%0d", n));
      val    = (neg && (n != 0)) ? -1 : n;
      usable = 1'b1;
    end else begin
      case ($urandom_range(0, 11))
        0: ;                                    // empty line
        1: put_str("2147483647");               // largest legal, too long to send
        2: put_str("2147483648");               // just above the 31-bit limit
        3: put_str("99999999999");
        4: begin
          put_str("-2147483648");
          val    = -1;
          usable = 1'b1;
        end
        5: begin                                // exactly the character limit
          repeat (NUMBER_CHARS - 1) put(CH_ZERO);
          put_str("1");
          val    = 1;
          usable = 1'b1;
        end
        6: begin                                // one character over
          repeat (NUMBER_CHARS) put(CH_ZERO);
          put_str("1");
        end
        7: put($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        8: put_str("+ 3");
        9: put_str("12x");
        10: put_str("7 ");
        default: repeat ($urandom_range(1, 4)) begin
          put_text_byte();
          if (last_is_cr()) frame_q[$] = 8'h71;
        end
      endcase
    end
  endfunction

  function automatic void put_simple();
    case ($urandom_range(0, 2))
      0:       put(CH_PLUS);
      1:       put(CH_MINUS);
      default: put(CH_COLON);
    endcase
    repeat ($urandom_range(0, 8)) put_text_byte();
    put_crlf();
  endfunction

  // One whole reply into frame_q; arrays are walked with a list of counts
  function automatic void build_frame();
    int   open_counts [$];
    int   val;
    logic usable;
    logic leaf;
    logic more;
    frame_q.delete();
    if ($urandom_range(0, 29) == 0) begin
      // nesting right at, or one past, the depth limit
      repeat (MAX_DEPTH + $urandom_range(0, 1)) begin
        put(CH_STAR);
        put_str("1");
        put_crlf();
      end
      put_simple();
      return;
    end
    more = 1'b1;
    while (more) begin
      leaf = 1'b1;
      s_pick: begin
        if (($urandom_range(0, 99) < 25) && (open_counts.size() < 4)) begin
          put(CH_STAR);
          put_number(1'b1, val, usable);
          put_crlf();
          if (!usable) begin
            more = 1'b0;
            leaf = 1'b0;
          end else if (val > 0) begin
            open_counts.push_back(val);
            leaf = 1'b0;
          end
        end else if ($urandom_range(0, 99) < 55) begin
          put(CH_DOLLAR);
          put_number(1'b0, val, usable);
          put_crlf();
          if (!usable) begin
            more = 1'b0;
            leaf = 1'b0;
          end else if (val >= 0) begin
            repeat (val) put(8'($urandom_range(0, 255)));
            put_crlf();
          end
        end else begin
          put_simple();
        end
      end
      if (leaf) begin
        while (open_counts.size() > 0) begin
          open_counts[open_counts.size()-1] = open_counts[open_counts.size()-1] - 1;
          if (open_counts[open_counts.size()-1] != 0) break;
          void'(open_counts.pop_back());
        end
        if (open_counts.size() == 0) more = 1'b0;
      end
    end
  endfunction

  // Move frame_q to the request stream; the first byte carries restart
  function automatic void queue_frame(logic first_restart);
    int i;
    for (i = 0; i < frame_q.size(); i++)
      byte_q.push_back({(i == 0) ? first_restart : 1'b0, frame_q[i]});
    frame_count = frame_count + 1;
  endfunction

  function automatic void build_directed();
    // straight out of reset, no restart needed; then a byte after completion
    frame_q.delete();
    put(CH_PLUS);
    put_crlf();
    put_str("Z");
    queue_frame(1'b0);
    // zero-length bulk string
    frame_q.delete();
    put(CH_DOLLAR);
    put_str("0");
    put_crlf();
    put_crlf();
    queue_frame(1'b1);
    // minus zero counts as zero: empty array
    frame_q.delete();
    put(CH_STAR);
    put_str("-0");
    put_crlf();
    queue_frame(1'b1);
    // unknown type byte, then a byte that the sticky error swallows
    frame_q.delete();
    put(8'h00);
    put(8'hFF);
    queue_frame(1'b1);
    // bulk trailer that is not CR LF
    frame_q.delete();
    put(CH_DOLLAR);
    put_str("1");
    put_crlf();
    put_str("A");
    put(CH_CR);
    put(CH_CR);
    queue_frame(1'b1);
  endfunction

  function automatic void build_random();
    int made;
    int i;
    made = 0;
    while (made < TARGET_REQS) begin
      if ($urandom_range(0, 19) == 0) begin
        // pure noise
        frame_q.delete();
        repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)));
      end else begin
        build_frame();
        // broken frames: one byte corrupted, or the tail cut off
        if ($urandom_range(0, 9) == 0)
          frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
        if ((frame_q.size() > 2) && ($urandom_range(0, 24) == 0))
          repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
      end
      made = made + frame_q.size();
      queue_frame(1'b1);
      // a restart inside the frame just begins a new one there
      if ((frame_q.size() > 1) && ($urandom_range(0, 29) == 0)) begin
        i = byte_q.size() - 1 - $urandom_range(0, frame_q.size() - 2);
        byte_q[i][8] = 1'b1;
      end
      // trailing bytes without restart are ignored by a finished parser
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) byte_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: a stall pattern drawn anew among four modes, plus one long
  // hold-off once the run is under way, so the block fills and drops in_ready.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int mode;
    int mode_age;
    int held;
    mode     = 0;
    mode_age = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_taken && (req_count >= HOLD_AFTER)) begin
        hold_taken  = 1'b1;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end
      mode_age = mode_age + 1;
      if (mode_age >= 150) begin
        mode_age = 0;
        mode     = $urandom_range(0, 3);
      end
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 9) < 7);
        2:       out_ready_i <= ((mode_age % 4) != 0);
        default: out_ready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request channel: bursts of random length with random gaps between them.
  // valid stays high across a burst; each request holds until accepted.
  // ---------------------------------------------------------------------------
  initial begin : request_side
    int         burst;
    int         gap;
    logic [8:0] req;
    build_directed();
    build_random();
    while (!rst_ni) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (byte_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while ((burst > 0) && (byte_q.size() > 0)) begin
        req = byte_q.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= req[7:0];
        restart_i   <= req[8];
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        req_count = req_count + 1;
        burst     = burst - 1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if ((gap > 0) && (byte_q.size() > 0)) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // drain: sample on the falling edge, clear of the checker's update
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);

    $display("Run: %0d requests in %0d frames, %0d complete and %0d malformed results seen",
             req_count, frame_count, complete_count, malformed_count);
    $display("Result side held off for %0d cycles once; %0d failures", HOLD_CYCLES,
             fail_count);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
